// ===== hdl/e2q_pkg.sv =====
package e2q_pkg;

  localparam int unsigned NUM_AXES     = 3;
  localparam int unsigned NUM_COMP     = 4;
  localparam int unsigned ANGLE_WIDTH  = 16;
  localparam int unsigned QUAT_WIDTH   = 16;
  localparam int unsigned HORNER_TERMS = 5;
  localparam int unsigned Q_SHIFT      = 30;

  localparam int unsigned AXIS_X = 0;
  localparam int unsigned AXIS_Y = 1;
  localparam int unsigned AXIS_Z = 2;

  localparam int unsigned COMP_X = 0;
  localparam int unsigned COMP_Y = 1;
  localparam int unsigned COMP_Z = 2;
  localparam int unsigned COMP_W = 3;

  // Half angles are counted in 1/128 degree.
  localparam logic [15:0] FULL_TURN     = 16'd46080;
  localparam logic [15:0] QUARTER_1     = 16'd11520;
  localparam logic [15:0] QUARTER_2     = 16'd23040;
  localparam logic [15:0] QUARTER_3     = 16'd34560;
  localparam logic [13:0] QUARTER_TURN  = 14'd11520;
  localparam logic [13:0] EIGHTH_TURN   = 14'd5760;

  // Radians in Q30 are r * pi * 2^30 / 23040, split into an integer and a fractional
  // coefficient; the fractional part is divided by 512 and then by 45 through a reciprocal.
  localparam logic [17:0] X_INT_COEF   = 18'd146408;
  localparam logic [14:0] X_FRAC_COEF  = 15'd19106;
  localparam logic [26:0] X_ROUND      = 27'd11520;
  localparam logic [18:0] RECIP_45     = 19'd372828;
  localparam int unsigned RECIP_SHIFT  = 24;

  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [29:0] ROUND_Q30    = 30'h2000_0000;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam int unsigned SIN_DIV [HORNER_TERMS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [HORNER_TERMS] = '{90, 56, 30, 12, 2};

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } e2q_oct_t;

  typedef struct packed {
    logic [29:0] x;
    e2q_oct_t    oct;
    logic [29:0] x2;
    logic [30:0] ts;
    logic [30:0] tc;
  } e2q_lane_t;

  // Rounds half away from zero while shifting right.
  function automatic logic signed [63:0] e2q_round_shift(input logic signed [63:0] v,
                                                          input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] m;
    mag  = v[63] ? 64'(-v) : 64'(v);
    half = 64'd1 << (sh - 1);
    m    = (mag + half) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== hdl/euler_to_quaternion.sv =====
// Pipeline: an accepted input transaction passes through 6 front stages, 5 Horner cells of
// 2 stages each and 7 composition stages before it leaves as an output transaction.
// Throughput: one transaction per cycle; every stage holds its item while stalled and
// takes a new one as soon as its successor frees up.
// Reset: rst_ni clears only the stage valid flags; no pass is needed after reset.
module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int unsigned QuatWidth = QUAT_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ANGLE_WIDTH-1:0] angle_x_i,
  input  logic [ANGLE_WIDTH-1:0] angle_y_i,
  input  logic [ANGLE_WIDTH-1:0] angle_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [QuatWidth-1:0]   quat_x_o,
  output logic [QuatWidth-1:0]   quat_y_o,
  output logic [QuatWidth-1:0]   quat_z_o,
  output logic [QuatWidth-1:0]   quat_w_o
);

  logic [NUM_AXES-1:0][ANGLE_WIDTH-1:0] angles;
  logic [NUM_COMP-1:0][QuatWidth-1:0]   quat;

  e2q_lane_t [NUM_AXES-1:0] lane  [HORNER_TERMS+1];
  logic                     valid [HORNER_TERMS+1];
  logic                     ready [HORNER_TERMS+1];

  assign angles[AXIS_X] = angle_x_i;
  assign angles[AXIS_Y] = angle_y_i;
  assign angles[AXIS_Z] = angle_z_i;

  e2q_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .angle_i (angles),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .lane_o  (lane[0])
  );

  for (genvar i = 0; i < HORNER_TERMS; i++) begin : g_cell
    e2q_cell #(
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .lane_i  (lane[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .lane_o  (lane[i+1])
    );
  end

  e2q_back #(
    .QuatWidth (QuatWidth)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[HORNER_TERMS]),
    .ready_o (ready[HORNER_TERMS]),
    .lane_i  (lane[HORNER_TERMS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .quat_o  (quat)
  );

  assign quat_x_o = quat[COMP_X];
  assign quat_y_o = quat[COMP_Y];
  assign quat_z_o = quat[COMP_Z];
  assign quat_w_o = quat[COMP_W];

endmodule

// ===== hdl/e2q_front.sv =====
module e2q_front
  import e2q_pkg::*;
(
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [NUM_AXES-1:0][ANGLE_WIDTH-1:0]  angle_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output e2q_lane_t [NUM_AXES-1:0]              lane_o
);

  localparam int unsigned Stages = 6;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] en;

  always_comb begin
    en[Stages-1] = !v_q[Stages-1] || ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[Stages-1];

  logic [15:0] u      [NUM_AXES];
  logic [13:0] r      [NUM_AXES];
  logic [12:0] rp_d   [NUM_AXES];
  e2q_oct_t    oct_d  [NUM_AXES];
  logic [26:0] t3     [NUM_AXES];
  logic [59:0] xx_rnd [NUM_AXES];

  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      u[l] = angle_i[l][15] ? angle_i[l] + FULL_TURN : angle_i[l];
      if (u[l] >= QUARTER_3) begin
        oct_d[l].quad = QUAD_3;
        r[l]          = 14'(u[l] - QUARTER_3);
      end else if (u[l] >= QUARTER_2) begin
        oct_d[l].quad = QUAD_2;
        r[l]          = 14'(u[l] - QUARTER_2);
      end else if (u[l] >= QUARTER_1) begin
        oct_d[l].quad = QUAD_1;
        r[l]          = 14'(u[l] - QUARTER_1);
      end else begin
        oct_d[l].quad = QUAD_0;
        r[l]          = u[l][13:0];
      end
      if (r[l] > EIGHTH_TURN) begin
        oct_d[l].swap = 1'b1;
        rp_d[l]       = 13'(QUARTER_TURN - r[l]);
      end else begin
        oct_d[l].swap = 1'b0;
        rp_d[l]       = r[l][12:0];
      end
    end
  end

  logic [12:0] s1_rp_q  [NUM_AXES];
  e2q_oct_t    s1_oct_q [NUM_AXES];
  logic [29:0] s2_ma_q  [NUM_AXES];
  logic [26:0] s2_mb_q  [NUM_AXES];
  e2q_oct_t    s2_oct_q [NUM_AXES];
  logic [29:0] s3_ma_q  [NUM_AXES];
  logic [36:0] s3_w_q   [NUM_AXES];
  e2q_oct_t    s3_oct_q [NUM_AXES];
  logic [29:0] s4_x_q   [NUM_AXES];
  e2q_oct_t    s4_oct_q [NUM_AXES];
  logic [59:0] s5_xx_q  [NUM_AXES];
  logic [29:0] s5_x_q   [NUM_AXES];
  e2q_oct_t    s5_oct_q [NUM_AXES];
  logic [29:0] s6_x2_q  [NUM_AXES];
  logic [29:0] s6_x_q   [NUM_AXES];
  e2q_oct_t    s6_oct_q [NUM_AXES];

  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      t3[l]     = s2_mb_q[l] + X_ROUND;
      xx_rnd[l] = s5_xx_q[l] + {30'd0, ROUND_Q30};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_AXES; l++) begin
      if (en[0]) begin
        s1_rp_q[l]  <= rp_d[l];
        s1_oct_q[l] <= oct_d[l];
      end
      if (en[1]) begin
        s2_ma_q[l]  <= 30'(s1_rp_q[l] * X_INT_COEF);
        s2_mb_q[l]  <= 27'(s1_rp_q[l] * X_FRAC_COEF);
        s2_oct_q[l] <= s1_oct_q[l];
      end
      if (en[2]) begin
        s3_ma_q[l]  <= s2_ma_q[l];
        s3_w_q[l]   <= t3[l][26:9] * RECIP_45;
        s3_oct_q[l] <= s2_oct_q[l];
      end
      if (en[3]) begin
        s4_x_q[l]   <= s3_ma_q[l] + 30'(s3_w_q[l][36:RECIP_SHIFT]);
        s4_oct_q[l] <= s3_oct_q[l];
      end
      if (en[4]) begin
        s5_xx_q[l]  <= s4_x_q[l] * s4_x_q[l];
        s5_x_q[l]   <= s4_x_q[l];
        s5_oct_q[l] <= s4_oct_q[l];
      end
      if (en[5]) begin
        s6_x2_q[l]  <= xx_rnd[l][59:30];
        s6_x_q[l]   <= s5_x_q[l];
        s6_oct_q[l] <= s5_oct_q[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      lane_o[l].x   = s6_x_q[l];
      lane_o[l].oct = s6_oct_q[l];
      lane_o[l].x2  = s6_x2_q[l];
      lane_o[l].ts  = ONE_Q30;
      lane_o[l].tc  = ONE_Q30;
    end
  end

endmodule

// ===== hdl/e2q_cell.sv =====
module e2q_cell
  import e2q_pkg::*;
#(
  parameter int unsigned Index = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  e2q_lane_t [NUM_AXES-1:0] lane_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output e2q_lane_t [NUM_AXES-1:0] lane_o
);

  localparam int unsigned SinDiv    = SIN_DIV[Index];
  localparam int unsigned CosDiv    = COS_DIV[Index];
  localparam int unsigned SinShift  = Q_SHIFT + $clog2(SinDiv);
  localparam int unsigned CosShift  = Q_SHIFT + $clog2(CosDiv);
  localparam logic [63:0] SinRecipW = ((64'd1 << SinShift) + 64'(SinDiv) - 64'd1) / SinDiv;
  localparam logic [63:0] CosRecipW = ((64'd1 << CosShift) + 64'(CosDiv) - 64'd1) / CosDiv;
  localparam logic [30:0] SinRecip  = SinRecipW[30:0];
  localparam logic [30:0] CosRecip  = CosRecipW[30:0];

  logic a_v_q, b_v_q;
  logic a_en, b_en;

  assign b_en    = !b_v_q || ready_i;
  assign a_en    = !a_v_q || b_en;
  assign ready_o = a_en;
  assign valid_o = b_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_v_q <= valid_i;
      end
      if (b_en) begin
        b_v_q <= a_v_q;
      end
    end
  end

  logic [29:0] a_x_q   [NUM_AXES];
  e2q_oct_t    a_oct_q [NUM_AXES];
  logic [29:0] a_x2_q  [NUM_AXES];
  logic [60:0] a_ps_q  [NUM_AXES];
  logic [60:0] a_pc_q  [NUM_AXES];
  logic [29:0] b_x_q   [NUM_AXES];
  e2q_oct_t    b_oct_q [NUM_AXES];
  logic [29:0] b_x2_q  [NUM_AXES];
  logic [60:0] b_qs_q  [NUM_AXES];
  logic [60:0] b_qc_q  [NUM_AXES];
  logic [60:0] rnd_s   [NUM_AXES];
  logic [60:0] rnd_c   [NUM_AXES];

  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      rnd_s[l] = a_ps_q[l] + {31'd0, ROUND_Q30};
      rnd_c[l] = a_pc_q[l] + {31'd0, ROUND_Q30};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_AXES; l++) begin
      if (a_en) begin
        a_x_q[l]   <= lane_i[l].x;
        a_oct_q[l] <= lane_i[l].oct;
        a_x2_q[l]  <= lane_i[l].x2;
        a_ps_q[l]  <= lane_i[l].x2 * lane_i[l].ts;
        a_pc_q[l]  <= lane_i[l].x2 * lane_i[l].tc;
      end
      if (b_en) begin
        b_x_q[l]   <= a_x_q[l];
        b_oct_q[l] <= a_oct_q[l];
        b_x2_q[l]  <= a_x2_q[l];
        b_qs_q[l]  <= rnd_s[l][59:30] * SinRecip;
        b_qc_q[l]  <= rnd_c[l][59:30] * CosRecip;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      lane_o[l].x   = b_x_q[l];
      lane_o[l].oct = b_oct_q[l];
      lane_o[l].x2  = b_x2_q[l];
      lane_o[l].ts  = ONE_Q30 - 31'(b_qs_q[l] >> SinShift);
      lane_o[l].tc  = ONE_Q30 - 31'(b_qc_q[l] >> CosShift);
    end
  end

endmodule

// ===== hdl/e2q_back.sv =====
module e2q_back
  import e2q_pkg::*;
#(
  parameter int unsigned QuatWidth = QUAT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  e2q_lane_t [NUM_AXES-1:0]            lane_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [NUM_COMP-1:0][QuatWidth-1:0]  quat_o
);

  localparam int unsigned Stages   = 7;
  localparam int unsigned OutShift = 61 - QuatWidth;
  localparam logic signed [63:0] Lim = (64'sd1 <<< (QuatWidth - 1)) - 64'sd1;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] en;

  always_comb begin
    en[Stages-1] = !v_q[Stages-1] || ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[Stages-1];

  logic        [60:0] s1_sp_q  [NUM_AXES];
  logic        [30:0] s1_tc_q  [NUM_AXES];
  e2q_oct_t           s1_oct_q [NUM_AXES];
  logic signed [31:0] s2_s_q   [NUM_AXES];
  logic signed [31:0] s2_c_q   [NUM_AXES];
  logic signed [63:0] s3_cysx_q, s3_sycx_q, s3_sysx_q, s3_cycx_q;
  logic signed [31:0] s3_sz_q, s3_cz_q;
  logic signed [31:0] s4_yx_q  [NUM_COMP];
  logic signed [31:0] s4_sz_q, s4_cz_q;
  logic signed [63:0] s5_pc_q  [NUM_COMP];
  logic signed [63:0] s5_ps_q  [NUM_COMP];
  logic signed [63:0] s6_sum_q [NUM_COMP];
  logic signed [63:0] s7_q_q   [NUM_COMP];

  logic        [60:0] sp_rnd   [NUM_AXES];
  logic        [30:0] sin_b    [NUM_AXES];
  logic        [30:0] cos_b    [NUM_AXES];
  logic signed [31:0] ps       [NUM_AXES];
  logic signed [31:0] pc       [NUM_AXES];
  logic signed [31:0] s_d      [NUM_AXES];
  logic signed [31:0] c_d      [NUM_AXES];
  logic signed [63:0] fin      [NUM_COMP];

  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      sp_rnd[l] = s1_sp_q[l] + {31'd0, ROUND_Q30};
      if (s1_oct_q[l].swap) begin
        sin_b[l] = s1_tc_q[l];
        cos_b[l] = sp_rnd[l][60:30];
      end else begin
        sin_b[l] = sp_rnd[l][60:30];
        cos_b[l] = s1_tc_q[l];
      end
      ps[l] = $signed({1'b0, sin_b[l]});
      pc[l] = $signed({1'b0, cos_b[l]});
      unique case (s1_oct_q[l].quad)
        QUAD_0: begin
          s_d[l] = ps[l];
          c_d[l] = pc[l];
        end
        QUAD_1: begin
          s_d[l] = pc[l];
          c_d[l] = -ps[l];
        end
        QUAD_2: begin
          s_d[l] = -ps[l];
          c_d[l] = -pc[l];
        end
        default: begin
          s_d[l] = -pc[l];
          c_d[l] = ps[l];
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      fin[k] = e2q_round_shift(s6_sum_q[k], OutShift);
      if (fin[k] > Lim) begin
        fin[k] = Lim;
      end else if (fin[k] < -Lim) begin
        fin[k] = -Lim;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_AXES; l++) begin
      if (en[0]) begin
        s1_sp_q[l]  <= lane_i[l].x * lane_i[l].ts;
        s1_tc_q[l]  <= lane_i[l].tc;
        s1_oct_q[l] <= lane_i[l].oct;
      end
      if (en[1]) begin
        s2_s_q[l] <= s_d[l];
        s2_c_q[l] <= c_d[l];
      end
    end
    if (en[2]) begin
      s3_cysx_q <= s2_c_q[AXIS_Y] * s2_s_q[AXIS_X];
      s3_sycx_q <= s2_s_q[AXIS_Y] * s2_c_q[AXIS_X];
      s3_sysx_q <= s2_s_q[AXIS_Y] * s2_s_q[AXIS_X];
      s3_cycx_q <= s2_c_q[AXIS_Y] * s2_c_q[AXIS_X];
      s3_sz_q   <= s2_s_q[AXIS_Z];
      s3_cz_q   <= s2_c_q[AXIS_Z];
    end
    if (en[3]) begin
      s4_yx_q[COMP_X] <= 32'(e2q_round_shift(s3_cysx_q, Q_SHIFT));
      s4_yx_q[COMP_Y] <= 32'(e2q_round_shift(s3_sycx_q, Q_SHIFT));
      s4_yx_q[COMP_Z] <= 32'(-e2q_round_shift(s3_sysx_q, Q_SHIFT));
      s4_yx_q[COMP_W] <= 32'(e2q_round_shift(s3_cycx_q, Q_SHIFT));
      s4_sz_q         <= s3_sz_q;
      s4_cz_q         <= s3_cz_q;
    end
    for (int k = 0; k < NUM_COMP; k++) begin
      if (en[4]) begin
        s5_pc_q[k] <= s4_yx_q[k] * s4_cz_q;
        s5_ps_q[k] <= s4_yx_q[k] * s4_sz_q;
      end
      if (en[6]) begin
        s7_q_q[k] <= fin[k];
      end
    end
    if (en[5]) begin
      s6_sum_q[COMP_X] <= s5_pc_q[COMP_X] + s5_ps_q[COMP_Y];
      s6_sum_q[COMP_Y] <= s5_pc_q[COMP_Y] - s5_ps_q[COMP_X];
      s6_sum_q[COMP_Z] <= s5_pc_q[COMP_Z] + s5_ps_q[COMP_W];
      s6_sum_q[COMP_W] <= s5_pc_q[COMP_W] - s5_ps_q[COMP_Z];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      quat_o[k] = s7_q_q[k][QuatWidth-1:0];
    end
  end

endmodule

// ===== tb/sv/euler_to_quaternion_checker.sv =====
module euler_to_quaternion_checker
  import e2q_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [ANGLE_WIDTH-1:0] angle_x_i,
  input  logic [ANGLE_WIDTH-1:0] angle_y_i,
  input  logic [ANGLE_WIDTH-1:0] angle_z_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [QUAT_WIDTH-1:0]  quat_x_i,
  input  logic [QUAT_WIDTH-1:0]  quat_y_i,
  input  logic [QUAT_WIDTH-1:0]  quat_z_i,
  input  logic [QUAT_WIDTH-1:0]  quat_w_i,
  output int unsigned            errors_o,
  output int unsigned            pending_o
);

  typedef longint unsigned u64_t;
  typedef longint          s64_t;
  typedef logic [NUM_COMP-1:0][QUAT_WIDTH-1:0] quat_t;

  localparam u64_t PI_SCALED  = 64'd3373259426;
  localparam u64_t UNIT_Q30   = 64'd1 << 30;
  localparam u64_t HALF_UNITS = 64'd23040;
  localparam int   TURN_UNITS = 46080;
  localparam int   QUAD_UNITS = 11520;
  localparam int   OCT_UNITS  = 5760;
  localparam int   SERIES_LEN = 5;

  localparam logic [SERIES_LEN-1:0][63:0] SINE_DIV =
    {64'd6, 64'd20, 64'd42, 64'd72, 64'd110};
  localparam logic [SERIES_LEN-1:0][63:0] COSINE_DIV =
    {64'd2, 64'd12, 64'd30, 64'd56, 64'd90};

  quat_t       expected_quats [$];
  quat_t       got_quat;
  quat_t       want_quat;
  int unsigned mismatch_count = 0;
  int unsigned outstanding = 0;
  string       comp_names [NUM_COMP] = '{"x", "y", "z", "w"};

  assign errors_o  = mismatch_count;
  assign pending_o = outstanding;

  function automatic u64_t q30_mul(input u64_t a, input u64_t b);
    return (a * b + (u64_t'(1) << 29)) >> 30;
  endfunction

  function automatic s64_t shift_round(input s64_t v, input int unsigned sh);
    u64_t half_lsb;
    u64_t mag;
    half_lsb = u64_t'(1) << (sh - 1);
    if (v < 0) begin
      mag = (u64_t'(-v) + half_lsb) >> sh;
      return -s64_t'(mag);
    end
    return s64_t'((u64_t'(v) + half_lsb) >> sh);
  endfunction

  // Sine and cosine in Q30 of an angle within the first octant.
  function automatic void octant_sin_cos(input int r, output u64_t s, output u64_t c);
    u64_t x;
    u64_t x2;
    u64_t ts;
    u64_t tc;
    int   i;
    x  = (u64_t'(r) * PI_SCALED + HALF_UNITS / 2) / HALF_UNITS;
    x2 = q30_mul(x, x);
    ts = UNIT_Q30;
    tc = UNIT_Q30;
    for (i = 0; i < SERIES_LEN; i++) begin
      ts = UNIT_Q30 - q30_mul(x2, ts) / SINE_DIV[i];
      tc = UNIT_Q30 - q30_mul(x2, tc) / COSINE_DIV[i];
    end
    s = q30_mul(x, ts);
    c = tc;
  endfunction

  // The raw angle count read in 1/128 degree is the half angle.
  function automatic void half_angle_trig(input logic [ANGLE_WIDTH-1:0] raw,
                                          output s64_t s, output s64_t c);
    int         a;
    int         u;
    int         rem;
    logic [1:0] quad;
    u64_t       bs;
    u64_t       bc;
    a = $signed(raw);
    u = a % TURN_UNITS;
    if (u < 0) begin
      u += TURN_UNITS;
    end
    quad = 2'(u / QUAD_UNITS);
    rem  = u % QUAD_UNITS;
    if (rem > OCT_UNITS) begin
      octant_sin_cos(QUAD_UNITS - rem, bc, bs);
    end else begin
      octant_sin_cos(rem, bs, bc);
    end
    case (quad)
      QUAD_0: begin
        s = s64_t'(bs);
        c = s64_t'(bc);
      end
      QUAD_1: begin
        s = s64_t'(bc);
        c = -s64_t'(bs);
      end
      QUAD_2: begin
        s = -s64_t'(bs);
        c = -s64_t'(bc);
      end
      default: begin
        s = -s64_t'(bc);
        c = s64_t'(bs);
      end
    endcase
  endfunction

  function automatic logic [QUAT_WIDTH-1:0] saturate_component(input s64_t q60);
    s64_t lim;
    s64_t v;
    lim = (s64_t'(1) << (QUAT_WIDTH - 1)) - 1;
    v   = shift_round(q60, 61 - QUAT_WIDTH);
    if (v > lim) begin
      v = lim;
    end
    if (v < -lim) begin
      v = -lim;
    end
    return v[QUAT_WIDTH-1:0];
  endfunction

  // Rotation order is yaw about y, then pitch about x, then roll about z.
  function automatic quat_t rotation_quat(input logic [ANGLE_WIDTH-1:0] ax,
                                          input logic [ANGLE_WIDTH-1:0] ay,
                                          input logic [ANGLE_WIDTH-1:0] az);
    s64_t  sx, cx, sy, cy, sz, cz;
    s64_t  px, py, pz, pw;
    quat_t q;
    half_angle_trig(ax, sx, cx);
    half_angle_trig(ay, sy, cy);
    half_angle_trig(az, sz, cz);
    px = shift_round(cy * sx, 30);
    py = shift_round(sy * cx, 30);
    pz = -shift_round(sy * sx, 30);
    pw = shift_round(cy * cx, 30);
    q[COMP_X] = saturate_component(px * cz + py * sz);
    q[COMP_Y] = saturate_component(py * cz - px * sz);
    q[COMP_Z] = saturate_component(pz * cz + pw * sz);
    q[COMP_W] = saturate_component(pw * cz - pz * sz);
    return q;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_quats.push_back(rotation_quat(angle_x_i, angle_y_i, angle_z_i));
      end
      if (out_valid_i && out_ready_i) begin
        got_quat = {quat_w_i, quat_z_i, quat_y_i, quat_x_i};
        if (expected_quats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected output transaction: x %0d y %0d z %0d w %0d",
                     $signed(quat_x_i), $signed(quat_y_i), $signed(quat_z_i),
                     $signed(quat_w_i));
          end
        end else begin
          want_quat = expected_quats.pop_front();
          for (int k = 0; k < NUM_COMP; k++) begin
            if (got_quat[k] !== want_quat[k]) begin
              mismatch_count++;
              if (mismatch_count <= 10) begin
                $display("quat_%s mismatch: expected %0d, got %0d", comp_names[k],
                         $signed(want_quat[k]), $signed(got_quat[k]));
              end
            end
          end
        end
      end
      outstanding = expected_quats.size();
    end
  end

endmodule

// ===== tb/sv/euler_to_quaternion_tb.sv =====
module euler_to_quaternion_tb;
  import e2q_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES  = 200000;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned ITEMS_PER_PHASE = 340;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ANGLE_WIDTH-1:0] angle_x = '0;
  logic [ANGLE_WIDTH-1:0] angle_y = '0;
  logic [ANGLE_WIDTH-1:0] angle_z = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [QUAT_WIDTH-1:0]  quat_x;
  logic [QUAT_WIDTH-1:0]  quat_y;
  logic [QUAT_WIDTH-1:0]  quat_z;
  logic [QUAT_WIDTH-1:0]  quat_w;
  int unsigned            quat_errors;
  int unsigned            quats_pending;
  int unsigned            send_idle_pct = 0;
  int unsigned            recv_stall_pct = 0;
  int unsigned            cycle_count = 0;

  euler_to_quaternion DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .angle_x_i   (angle_x),
    .angle_y_i   (angle_y),
    .angle_z_i   (angle_z),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .quat_x_o    (quat_x),
    .quat_y_o    (quat_y),
    .quat_z_o    (quat_z),
    .quat_w_o    (quat_w)
  );

  euler_to_quaternion_checker quat_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .angle_x_i   (angle_x),
    .angle_y_i   (angle_y),
    .angle_z_i   (angle_z),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .quat_x_i    (quat_x),
    .quat_y_i    (quat_y),
    .quat_z_i    (quat_z),
    .quat_w_i    (quat_w),
    .errors_o    (quat_errors),
    .pending_o   (quats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_angles(input int ax, input int ay, input int az);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    angle_x  <= ax[ANGLE_WIDTH-1:0];
    angle_y  <= ay[ANGLE_WIDTH-1:0];
    angle_z  <= az[ANGLE_WIDTH-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_quats;
    in_valid <= 1'b0;
    do @(posedge clk); while (quats_pending != 0);
  endtask

  // Mostly angles within one turn, sometimes any 16-bit pattern.
  function automatic int random_angle();
    if ($urandom_range(7) == 0) begin
      return int'($urandom_range(65535)) - 32768;
    end
    return int'($urandom_range(46080)) - 23040;
  endfunction

  task automatic run_random_phase(input int unsigned sender_pct,
                                  input int unsigned receiver_pct);
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
    repeat (ITEMS_PER_PHASE) begin
      send_angles(random_angle(), random_angle(), random_angle());
    end
    wait_for_quats();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_angles(0, 0, 0);
    send_angles(23040, 23040, 23040);
    send_angles(-23040, -23040, -23040);
    send_angles(32767, -32768, 32767);
    send_angles(-32768, 32767, -32768);
    send_angles(-1, 1, -1);
    send_angles(5760, 0, 0);
    send_angles(0, 5760, 0);
    send_angles(0, 0, 5760);
    send_angles(11520, 11520, 11520);
    send_angles(11519, 11521, 11522);
    send_angles(5759, 5761, 17281);
    send_angles(17280, -17280, 17279);
    send_angles(23039, 23041, 23040);
    send_angles(34559, 34560, 34561);
    send_angles(-11520, -5760, -11521);
    send_angles(-34560, -23041, 46079 - 65536);
    send_angles(21845, -21846, 21845);
    send_angles(-21846, 21845, -21846);
    send_angles(8192, -8192, 16384);
    send_angles(90 * 64, 45 * 64, -30 * 64);
    send_angles(180 * 64, -90 * 64, 270 * 64);
    wait_for_quats();

    run_random_phase(0, 0);
    run_random_phase(57, 0);
    run_random_phase(0, 57);
    run_random_phase(23, 23);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (quat_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
